FILE: design/lsb_stego_extractor_core_macros.svh
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Shared concurrent assertion wrappers, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACTOR_CORE_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_CORE_MACROS_SVH

// checked outside reset
`define LSBX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define LSBX_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/lsbx_pkg.sv
// ----------------------------------------------------------------------------
// lsbx_pkg
// Types and constants for the LSB stego extractor.
// ----------------------------------------------------------------------------
package lsbx_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [1:0] REG_HEADER_LENGTH = 2'd0;
   localparam logic [1:0] REG_MAGIC_FIRST   = 2'd1;
   localparam logic [1:0] REG_MAGIC_SECOND  = 2'd2;

   localparam logic [7:0] HEADER_LENGTH_RESET = 8'd54;

   localparam logic [2:0] KIND_EXT_CHAR  = 3'd0;
   localparam logic [2:0] KIND_SEC_BYTE  = 3'd1;
   localparam logic [2:0] KIND_EXT_LEN   = 3'd2;
   localparam logic [2:0] KIND_SEC_LEN   = 3'd3;
   localparam logic [2:0] KIND_MISMATCH  = 3'd4;

   typedef enum logic [6:0] {
      PH_HEADER  = 7'b0000001,
      PH_MAGIC   = 7'b0000010,
      PH_EXT_LEN = 7'b0000100,
      PH_EXT_CHR = 7'b0001000,
      PH_SEC_LEN = 7'b0010000,
      PH_SEC_DAT = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] header_length;
      logic [7:0] magic_first;
      logic [7:0] magic_second;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } result_type;

endpackage

FILE: design/lsbx_intf.sv
// ----------------------------------------------------------------------------
// lsbx interfaces
// Valid/ready channels for image byte requests and decoded results.
// ----------------------------------------------------------------------------
interface lsbx_req_intf;
   logic       valid;
   logic       ready;
   logic [7:0] image_byte;
   logic       start_req;

   modport source (output valid, output image_byte, output start_req, input ready);
   modport sink   (input valid, input image_byte, input start_req, output ready);
endinterface

interface lsbx_rsp_intf;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic        last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

FILE: design/lsbx_csr.sv
// ----------------------------------------------------------------------------
// lsbx_csr
// APB register file: header length and the two expected magic characters.
// ----------------------------------------------------------------------------
module lsbx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lsbx_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lsbx_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lsbx_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output lsbx_pkg::cfg_type                cfg
);
   import lsbx_pkg::*;

   logic [7:0] header_length_ff, header_length_in;
   logic [7:0] magic_first_ff, magic_first_in;
   logic [7:0] magic_second_ff, magic_second_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      header_length_in = header_length_ff;
      magic_first_in   = magic_first_ff;
      magic_second_in  = magic_second_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_HEADER_LENGTH: header_length_in = pwdata[7:0];
            REG_MAGIC_FIRST:   magic_first_in   = pwdata[7:0];
            REG_MAGIC_SECOND:  magic_second_in  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HEADER_LENGTH: prdata = {24'd0, header_length_ff};
         REG_MAGIC_FIRST:   prdata = {24'd0, magic_first_ff};
         REG_MAGIC_SECOND:  prdata = {24'd0, magic_second_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= HEADER_LENGTH_RESET;
         magic_first_ff   <= 8'd0;
         magic_second_ff  <= 8'd0;
      end else begin
         header_length_ff <= header_length_in;
         magic_first_ff   <= magic_first_in;
         magic_second_ff  <= magic_second_in;
      end
   end

   assign cfg.header_length = header_length_ff;
   assign cfg.magic_first   = magic_first_ff;
   assign cfg.magic_second  = magic_second_ff;

endmodule

FILE: design/lsbx_parser.sv
// ----------------------------------------------------------------------------
// lsbx_parser
// Parse state and one-bit step: header skip, magic check, length words,
// extension characters and secret bytes.
// ----------------------------------------------------------------------------
module lsbx_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 data_bit,
   input  logic                 start_req,
   input  lsbx_pkg::cfg_type    cfg,
   output lsbx_pkg::result_type result
);
   import lsbx_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_count_ff, header_count_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [31:0] bit_shift_ff, bit_shift_in;
   logic [30:0] remaining_ff, remaining_in;
   logic        magic_index_ff, magic_index_in;

   phase_type   ph;
   logic [7:0]  hc;
   logic [4:0]  bc;
   logic [31:0] bs;
   logic [30:0] rem;
   logic        mi;
   logic [4:0]  sh_amt;
   logic [31:0] shifted;
   logic [31:0] len;
   logic [30:0] rem_dec;
   logic        is_ext;

   always_comb begin
      ph  = start_req ? PH_HEADER : phase_ff;
      hc  = start_req ? 8'd0      : header_count_ff;
      bc  = start_req ? 5'd0      : bit_count_ff;
      bs  = start_req ? 32'd0     : bit_shift_ff;
      rem = start_req ? 31'd0     : remaining_ff;
      mi  = start_req ? 1'b0      : magic_index_ff;

      phase_in        = ph;
      header_count_in = hc;
      bit_count_in    = bc;
      bit_shift_in    = bs;
      remaining_in    = rem;
      magic_index_in  = mi;
      result          = '0;

      if (ph == PH_HEADER) begin
         if (hc < cfg.header_length) begin
            header_count_in = hc + 8'd1;
         end else begin
            phase_in = PH_MAGIC;
         end
      end

      unique case (phase_in)
         PH_MAGIC:                sh_amt = {1'b0, mi, bc[2:0]};
         PH_EXT_LEN, PH_SEC_LEN:  sh_amt = bc;
         default:                 sh_amt = {2'b00, bc[2:0]};
      endcase
      shifted = bs | (32'(data_bit) << sh_amt);
      len     = shifted[31] ? 32'd0 : shifted;
      rem_dec = (rem != 31'd0) ? rem - 31'd1 : 31'd0;
      is_ext  = (phase_in == PH_EXT_LEN) || (phase_in == PH_EXT_CHR);

      unique case (phase_in)
         PH_MAGIC: begin
            bit_shift_in = shifted;
            if (bc < 5'd7) begin
               bit_count_in = bc + 5'd1;
            end else begin
               bit_count_in = 5'd0;
               if (!mi) begin
                  magic_index_in = 1'b1;
               end else begin
                  magic_index_in = 1'b0;
                  bit_shift_in   = 32'd0;
                  if (shifted[7:0] != cfg.magic_first ||
                      shifted[15:8] != cfg.magic_second) begin
                     phase_in     = PH_DONE;
                     result.valid = 1'b1;
                     result.kind  = KIND_MISMATCH;
                  end else begin
                     phase_in = PH_EXT_LEN;
                  end
               end
            end
         end
         PH_EXT_LEN, PH_SEC_LEN: begin
            bit_shift_in = shifted;
            if (bc < 5'd31) begin
               bit_count_in = bc + 5'd1;
            end else begin
               bit_count_in = 5'd0;
               bit_shift_in = 32'd0;
               remaining_in = len[30:0];
               if (is_ext) begin
                  phase_in = (len != 32'd0) ? PH_EXT_CHR : PH_SEC_LEN;
               end else begin
                  phase_in = (len != 32'd0) ? PH_SEC_DAT : PH_DONE;
               end
               result.valid = 1'b1;
               result.kind  = is_ext ? KIND_EXT_LEN : KIND_SEC_LEN;
               result.value = len;
            end
         end
         PH_EXT_CHR, PH_SEC_DAT: begin
            bit_shift_in = shifted;
            if (bc < 5'd7) begin
               bit_count_in = bc + 5'd1;
            end else begin
               bit_count_in = 5'd0;
               bit_shift_in = 32'd0;
               remaining_in = rem_dec;
               if (rem_dec == 31'd0) begin
                  phase_in = is_ext ? PH_SEC_LEN : PH_DONE;
               end
               result.valid = 1'b1;
               result.kind  = is_ext ? KIND_EXT_CHAR : KIND_SEC_BYTE;
               result.value = {24'd0, shifted[7:0]};
               result.last  = (rem_dec == 31'd0);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 8'd0;
         bit_count_ff    <= 5'd0;
         bit_shift_ff    <= 32'd0;
         remaining_ff    <= 31'd0;
         magic_index_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_count_ff    <= bit_count_in;
         bit_shift_ff    <= bit_shift_in;
         remaining_ff    <= remaining_in;
         magic_index_ff  <= magic_index_in;
      end
   end

endmodule

FILE: design/lsb_stego_extractor_core.sv
// ----------------------------------------------------------------------------
// lsb_stego_extractor_core
// Pulls hidden LSB fields (magic, lengths, extension, secret) out of a
// stream of bitmap file bytes.
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        image_byte[7:0], start_req
//   rsp_bus  out  valid/ready        kind[2:0], value[31:0], last
//   csr      in   APB psel/penable   paddr[3:0], pwdata/prdata[31:0]
//
// One request per cycle while the result channel is not stalled.
// A request is registered, parsed in one pass, and its result registered.
// A stalled result holds the request register; a new request enters while
// that register is empty or its request is being passed on to the parser.
// Synchronous reset returns the parse to header skip and clears both stages.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_core (
   input  logic                             clock,
   input  logic                             reset,
   lsbx_req_intf.sink                       req_bus,
   lsbx_rsp_intf.source                     rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lsbx_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [lsbx_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [lsbx_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import lsbx_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic        in_valid_ff, in_valid_in;
   logic        in_bit_ff, in_bit_in;
   logic        in_start_ff, in_start_in;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_last_ff, out_last_in;
   logic        step_en;
   logic        req_take;

   lsbx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lsbx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_bit  (in_bit_ff),
      .start_req (in_start_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign step_en       = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | step_en;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_bit_in   = in_bit_ff;
      in_start_in = in_start_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_bit_in   = req_bus.image_byte[0];
         in_start_in = req_bus.start_req;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (step_en) begin
         out_valid_in = result.valid;
         out_kind_in  = result.kind;
         out_value_in = result.value;
         out_last_in  = result.last;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_bit_ff    <= in_bit_in;
      in_start_ff  <= in_start_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.kind  = out_kind_ff;
   assign rsp_bus.value = out_value_ff;
   assign rsp_bus.last  = out_last_ff;

endmodule

FILE: design/lsbx_checker.sv
// ----------------------------------------------------------------------------
// lsbx_checker
// Port-level checks on the result channel of the extractor core.
// ----------------------------------------------------------------------------
`include "lsb_stego_extractor_core_macros.svh"

module lsbx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_value,
   input logic        rsp_last
);
   import lsbx_pkg::*;

   `LSBX_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")
   `LSBX_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_last), "stalled result changed")
   `LSBX_ASSERT(a_last_kind, rsp_valid && rsp_last |-> rsp_kind == KIND_EXT_CHAR || rsp_kind == KIND_SEC_BYTE, "last flag on non-data result")
   `LSBX_ASSERT(a_mismatch_zero, rsp_valid && rsp_kind == KIND_MISMATCH |-> rsp_value == 32'd0 && !rsp_last, "mismatch result carries data")
   `LSBX_ASSERT(a_len_range, rsp_valid && (rsp_kind == KIND_EXT_LEN || rsp_kind == KIND_SEC_LEN) |-> !rsp_value[31], "length with top bit set")

endmodule

bind lsb_stego_extractor_core lsbx_checker u_lsbx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_kind  (rsp_bus.kind),
   .rsp_value (rsp_bus.value),
   .rsp_last  (rsp_bus.last)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for lsb_stego_extractor_core
// Streams image file requests (header, magic, lengths, extension, secret,
// truncated files, noise) through the request channel, predicts each decoded
// result in a cycle-free model, and checks every result field in order.
// Registers are rewritten over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbx_pkg::*;

   localparam int NO_CUT = 1 << 30;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } image_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } decoded_type;

   logic clock;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       req_start = 1'b0;
   logic       rsp_ready = 1'b0;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lsbx_req_intf req_if ();
   lsbx_rsp_intf rsp_if ();

   assign req_if.valid      = req_valid;
   assign req_if.image_byte = req_byte;
   assign req_if.start_req  = req_start;
   assign rsp_if.ready      = rsp_ready;

   lsb_stego_extractor_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   image_item_type image_q[$];
   decoded_type    decoded_q[$];

   int send_idle = 31;
   int recv_idle = 62;
   int errors    = 0;
   int pushed    = 0;
   int file_budget = NO_CUT;
   logic next_start = 1'b0;

   // predictor copy of registers and parse state
   logic [7:0]  cfg_hdr;
   logic [7:0]  cfg_magic1;
   logic [7:0]  cfg_magic2;
   phase_type   ph;
   logic [7:0]  hdr_cnt;
   logic [4:0]  bit_cnt;
   logic [31:0] shreg;
   logic [31:0] remain;
   logic        mag_idx;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void restart_parse();
      ph      = PH_HEADER;
      hdr_cnt = '0;
      bit_cnt = '0;
      shreg   = '0;
      remain  = '0;
      mag_idx = 1'b0;
   endfunction

   function automatic bit extract_step(input logic [7:0] b, input logic st,
                                       output decoded_type r);
      logic [31:0] len;
      logic        is_ext;
      r = '{kind: KIND_EXT_CHAR, value: '0, last: 1'b0};
      if (st) restart_parse();
      if (ph == PH_HEADER) begin
         if (hdr_cnt < cfg_hdr) begin
            hdr_cnt++;
            return 1'b0;
         end
         ph = PH_MAGIC;
      end
      case (ph) inside
         PH_MAGIC: begin
            shreg[{mag_idx, bit_cnt[2:0]}] |= b[0];
            if (bit_cnt < 5'd7) begin
               bit_cnt++;
               return 1'b0;
            end
            bit_cnt = '0;
            if (!mag_idx) begin
               mag_idx = 1'b1;
               return 1'b0;
            end
            mag_idx = 1'b0;
            if (shreg[7:0] != cfg_magic1 || shreg[15:8] != cfg_magic2) begin
               shreg  = '0;
               ph     = PH_DONE;
               r.kind = KIND_MISMATCH;
               return 1'b1;
            end
            shreg = '0;
            ph    = PH_EXT_LEN;
            return 1'b0;
         end
         PH_EXT_LEN, PH_SEC_LEN: begin
            shreg[bit_cnt] |= b[0];
            if (bit_cnt < 5'd31) begin
               bit_cnt++;
               return 1'b0;
            end
            is_ext  = (ph == PH_EXT_LEN);
            len     = shreg[31] ? 32'd0 : shreg;
            bit_cnt = '0;
            shreg   = '0;
            remain  = len;
            if (is_ext) ph = (len != 0) ? PH_EXT_CHR : PH_SEC_LEN;
            else ph = (len != 0) ? PH_SEC_DAT : PH_DONE;
            r.kind  = is_ext ? KIND_EXT_LEN : KIND_SEC_LEN;
            r.value = len;
            return 1'b1;
         end
         PH_EXT_CHR, PH_SEC_DAT: begin
            shreg[bit_cnt[2:0]] |= b[0];
            if (bit_cnt < 5'd7) begin
               bit_cnt++;
               return 1'b0;
            end
            is_ext  = (ph == PH_EXT_CHR);
            r.value = {24'd0, shreg[7:0]};
            bit_cnt = '0;
            shreg   = '0;
            if (remain != 0) remain--;
            if (remain == 0) ph = is_ext ? PH_SEC_LEN : PH_DONE;
            r.kind = is_ext ? KIND_EXT_CHAR : KIND_SEC_BYTE;
            r.last = (remain == 0);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin : drv
      image_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_if.ready) begin
         if (image_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            item = image_q.pop_front();
            req_valid <= 1'b1;
            req_byte  <= item.data;
            req_start <= item.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (a !== e) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   // result monitor and request predictor
   always @(posedge clock) begin : mon
      decoded_type got;
      decoded_type exp_item;
      decoded_type pred;
      if (!reset) begin
         if (rsp_if.valid && rsp_ready) begin
            got = '{kind: rsp_if.kind, value: rsp_if.value, last: rsp_if.last};
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                        $time, got.kind, got.value);
               errors++;
            end else begin
               exp_item = decoded_q.pop_front();
               check_field("kind", 32'(exp_item.kind), 32'(got.kind));
               check_field("value", exp_item.value, got.value);
               check_field("last", 32'(exp_item.last), 32'(got.last));
            end
         end
         if (req_valid && req_if.ready) begin
            if (extract_step(req_byte, req_start, pred)) decoded_q.push_back(pred);
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_HEADER_LENGTH: cfg_hdr    = val;
         REG_MAGIC_FIRST:   cfg_magic1 = val;
         REG_MAGIC_SECOND:  cfg_magic2 = val;
         default: ;
      endcase
   endtask

   task automatic put_byte(input logic [7:0] b);
      if (file_budget <= 0) return;
      image_q.push_back('{data: b, start: next_start});
      next_start = 1'b0;
      file_budget--;
      pushed++;
   endtask

   // one hidden bit per request, LSB first, upper bits random
   task automatic put_bits(input logic [31:0] v, input int n);
      logic [7:0] rb;
      for (int i = 0; i < n; i++) begin
         rb    = 8'($urandom);
         rb[0] = v[i];
         put_byte(rb);
      end
   endtask

   task automatic put_file(input logic st, input int hdr_n, input logic [7:0] m1,
                           input logic [7:0] m2, input logic [31:0] elen,
                           input logic [31:0] slen, input int tail, input int cut);
      logic [31:0] ecnt;
      logic [31:0] scnt;
      next_start  = st;
      file_budget = cut;
      ecnt = elen[31] ? 32'd0 : elen;
      scnt = slen[31] ? 32'd0 : slen;
      repeat (hdr_n) put_byte(8'($urandom));
      put_bits({24'd0, m1}, 8);
      put_bits({24'd0, m2}, 8);
      put_bits(elen, 32);
      for (int unsigned i = 0; i < ecnt && file_budget > 0; i++) put_bits($urandom, 8);
      put_bits(slen, 32);
      for (int unsigned i = 0; i < scnt && file_budget > 0; i++) put_bits($urandom, 8);
      repeat (tail) put_byte(8'($urandom));
   endtask

   function automatic logic [31:0] pick_len(input int small_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 80) return $urandom_range(1, small_max);
      if (r < 92) return {1'b1, 31'($urandom)};
      return {1'b0, 31'($urandom)};
   endfunction

   // hold until no request is pending and every result has come, plus latency slack
   task automatic wait_idle();
      while (image_q.size() != 0 || req_valid || decoded_q.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   initial begin : stim
      int          phase_start;
      int          hdr_n;
      int          cut;
      int          k;
      logic [7:0]  m1;
      logic [7:0]  m2;
      logic [31:0] elen;
      logic [31:0] slen;

      cfg_hdr    = HEADER_LENGTH_RESET;
      cfg_magic1 = 8'h00;
      cfg_magic2 = 8'h00;
      restart_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed files
      csr_write(REG_HEADER_LENGTH, 8'd2);
      csr_write(REG_MAGIC_FIRST, 8'hA5);
      csr_write(REG_MAGIC_SECOND, 8'h5A);
      @(negedge clock);
      // parse from reset with no start, empty extension
      put_file(1'b0, 2, 8'hA5, 8'h5A, 32'd0, 32'd1, 2, NO_CUT);
      // extreme bytes and chars, empty secret
      next_start  = 1'b1;
      file_budget = NO_CUT;
      put_byte(8'hFF);
      put_byte(8'h00);
      put_bits(32'hA5, 8);
      put_bits(32'h5A, 8);
      put_bits(32'd2, 32);
      put_bits(32'h00, 8);
      put_bits(32'hFF, 8);
      put_bits(32'd0, 32);
      put_byte(8'hFF);
      // magic mismatches, then ignored bytes
      put_file(1'b1, 2, 8'hA5, 8'h00, 32'd1, 32'd1, 3, NO_CUT);
      put_file(1'b1, 2, 8'h00, 8'h5A, 32'd1, 32'd1, 3, NO_CUT);
      // lengths with bit 31 set read as zero
      put_file(1'b1, 2, 8'hA5, 8'h5A, 32'h8000_0003, 32'hFFFF_FFFF, 1, NO_CUT);
      // huge extension cut short by a new start
      put_file(1'b1, 2, 8'hA5, 8'h5A, 32'h7FFF_FFFF, 32'd0, 0, 60);
      put_file(1'b1, 2, 8'hA5, 8'h5A, 32'd1, 32'd3, 0, NO_CUT);
      wait_idle();

      for (int p = 0; p < 5; p++) begin
         if (p == 2) begin
            send_idle = 62;
            recv_idle = 31;
         end
         if (p == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (p)
            0: begin
               csr_write(REG_HEADER_LENGTH, 8'd0);
               csr_write(REG_MAGIC_FIRST, 8'h00);
               csr_write(REG_MAGIC_SECOND, 8'h00);
            end
            1: begin
               csr_write(REG_HEADER_LENGTH, 8'd255);
               csr_write(REG_MAGIC_FIRST, 8'hFF);
               csr_write(REG_MAGIC_SECOND, 8'hFF);
            end
            4: begin
               csr_write(REG_HEADER_LENGTH, 8'd1);
               csr_write(REG_MAGIC_FIRST, 8'hFF);
               csr_write(REG_MAGIC_SECOND, 8'h00);
            end
            default: begin
               csr_write(REG_HEADER_LENGTH, 8'($urandom_range(0, 6)));
               csr_write(REG_MAGIC_FIRST, 8'($urandom));
               csr_write(REG_MAGIC_SECOND, 8'($urandom));
            end
         endcase
         @(negedge clock);
         phase_start = pushed;
         while (pushed - phase_start < 50) begin
            if ($urandom_range(0, 9) == 0) begin
               file_budget = NO_CUT;
               repeat ($urandom_range(1, 12)) begin
                  next_start = ($urandom_range(0, 5) == 0);
                  put_byte(8'($urandom));
               end
            end else begin
               hdr_n = ($urandom_range(0, 9) != 0) ? int'(cfg_hdr) : $urandom_range(0, 7);
               m1 = cfg_magic1;
               m2 = cfg_magic2;
               if ($urandom_range(0, 99) < 15) begin
                  k = $urandom_range(0, 15);
                  if (k < 8) m1[k] = ~m1[k];
                  else m2[k - 8] = ~m2[k - 8];
               end
               elen = pick_len(4);
               slen = pick_len(6);
               if ((!elen[31] && elen > 64) || (!slen[31] && slen > 64))
                  cut = $urandom_range(40, 160);
               else if ($urandom_range(0, 99) < 15)
                  cut = $urandom_range(1, 120);
               else
                  cut = NO_CUT;
               put_file(1'b1, hdr_n, m1, m2, elen, slen, $urandom_range(0, 3), cut);
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
